FILE: src/cee_pkg.sv
`default_nettype none

package cee_pkg;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX,
    MODE_OCT,
    MODE_CTRL
  } mode_t;

  // One request from the scanner to the emitter: one or two characters.
  typedef struct packed {
    logic        two;
    logic [31:0] char0;
    logic [31:0] char1;
  } req_t;

  localparam int QUEUE_DEPTH = 4;

  // Characters the scanner recognizes.
  localparam logic [20:0] CH_BSLASH = 21'h5C;
  localparam logic [20:0] CH_QUEST  = 21'h3F;
  localparam logic [20:0] CH_DQUOTE = 21'h22;
  localparam logic [20:0] CH_SQUOTE = 21'h27;
  localparam logic [20:0] CH_DIG0   = 21'h30;
  localparam logic [20:0] CH_DIG7   = 21'h37;
  localparam logic [20:0] CH_DIG9   = 21'h39;
  localparam logic [20:0] CH_UC_A   = 21'h41;
  localparam logic [20:0] CH_UC_E   = 21'h45;
  localparam logic [20:0] CH_UC_F   = 21'h46;
  localparam logic [20:0] CH_UC_U   = 21'h55;
  localparam logic [20:0] CH_LC_A   = 21'h61;
  localparam logic [20:0] CH_LC_B   = 21'h62;
  localparam logic [20:0] CH_LC_C   = 21'h63;
  localparam logic [20:0] CH_LC_E   = 21'h65;
  localparam logic [20:0] CH_LC_F   = 21'h66;
  localparam logic [20:0] CH_LC_N   = 21'h6E;
  localparam logic [20:0] CH_LC_R   = 21'h72;
  localparam logic [20:0] CH_LC_T   = 21'h74;
  localparam logic [20:0] CH_LC_U   = 21'h75;
  localparam logic [20:0] CH_LC_V   = 21'h76;
  localparam logic [20:0] CH_LC_X   = 21'h78;

  // Control codes produced by the named escapes.
  localparam logic [31:0] CTL_BEL = 32'd7;
  localparam logic [31:0] CTL_BS  = 32'd8;
  localparam logic [31:0] CTL_HT  = 32'd9;
  localparam logic [31:0] CTL_LF  = 32'd10;
  localparam logic [31:0] CTL_VT  = 32'd11;
  localparam logic [31:0] CTL_FF  = 32'd12;
  localparam logic [31:0] CTL_CR  = 32'd13;
  localparam logic [31:0] CTL_ESC = 32'd27;

  // Digit limits of the numeric escapes.
  localparam logic [3:0] LIM_X   = 4'd2;
  localparam logic [3:0] LIM_U   = 4'd4;
  localparam logic [3:0] LIM_UU  = 4'd8;
  localparam logic [3:0] LIM_OCT = 4'd3;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
  function automatic logic [4:0] hex_nibble(input logic [20:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/cee_in_if.sv
`default_nettype none

interface cee_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        end_of_text;

  modport source(output valid, output code_point, output end_of_text, input ready);
  modport sink(input valid, input code_point, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: src/cee_out_if.sv
`default_nettype none

interface cee_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_char;
  logic        last_of_run;

  modport source(output valid, output out_char, output last_of_run, input ready);
  modport sink(input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/cee_front.sv
`default_nettype none

module cee_front (
  input  wire logic         clk,
  input  wire logic         rst,
  cee_in_if.sink            feed,
  input  wire logic         queue_full,
  output cee_pkg::req_t     push_req,
  output logic              push
);

  cee_pkg::mode_t mode, mode_next;
  logic [3:0]     digit_count, digit_count_next;
  logic [3:0]     digit_limit, digit_limit_next;
  logic [31:0]    number_accum, number_accum_next;

  logic        accept;
  logic [20:0] c;
  logic        eot;
  logic        is_bslash;
  logic        num_mode;
  logic [4:0]  hex_dec;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic        take_digit;
  logic [31:0] accum_shift;
  logic [1:0]  n_out;
  logic [31:0] char0, char1;

  assign feed.ready = !queue_full;
  assign accept     = feed.valid && !queue_full;
  assign c          = feed.code_point;
  assign eot        = feed.end_of_text;
  assign is_bslash  = (c == cee_pkg::CH_BSLASH);
  assign num_mode   = (mode == cee_pkg::MODE_HEX) || (mode == cee_pkg::MODE_OCT);
  assign hex_dec    = cee_pkg::hex_nibble(c);

  always_comb begin
    if (mode == cee_pkg::MODE_OCT) begin
      dig_ok  = (c >= cee_pkg::CH_DIG0) && (c <= cee_pkg::CH_DIG7);
      dig_val = {1'b0, c[2:0]};
    end else begin
      dig_ok  = hex_dec[4];
      dig_val = hex_dec[3:0];
    end
  end

  assign take_digit = num_mode && dig_ok && (digit_count < digit_limit);

  always_comb begin
    if (mode == cee_pkg::MODE_OCT) begin
      accum_shift = {number_accum[28:0], 3'b000} | {28'b0, dig_val};
    end else begin
      accum_shift = {number_accum[27:0], 4'b0000} | {28'b0, dig_val};
    end
  end

  // Next state.
  always_comb begin
    mode_next         = mode;
    digit_count_next  = digit_count;
    digit_limit_next  = digit_limit;
    number_accum_next = number_accum;
    if (eot) begin
      mode_next         = cee_pkg::MODE_NORMAL;
      digit_count_next  = '0;
      digit_limit_next  = '0;
      number_accum_next = '0;
    end else begin
      case (mode)
        cee_pkg::MODE_ESC: begin
          mode_next = cee_pkg::MODE_NORMAL;
          case (c) inside
            cee_pkg::CH_LC_C: begin
              mode_next = cee_pkg::MODE_CTRL;
            end
            cee_pkg::CH_LC_X, cee_pkg::CH_LC_U, cee_pkg::CH_UC_U: begin
              mode_next         = cee_pkg::MODE_HEX;
              digit_count_next  = '0;
              number_accum_next = '0;
              if (c == cee_pkg::CH_LC_X) begin
                digit_limit_next = cee_pkg::LIM_X;
              end else if (c == cee_pkg::CH_LC_U) begin
                digit_limit_next = cee_pkg::LIM_U;
              end else begin
                digit_limit_next = cee_pkg::LIM_UU;
              end
            end
            [cee_pkg::CH_DIG0:cee_pkg::CH_DIG7]: begin
              mode_next         = cee_pkg::MODE_OCT;
              digit_count_next  = 4'd1;
              digit_limit_next  = cee_pkg::LIM_OCT;
              number_accum_next = {29'b0, c[2:0]};
            end
            default: begin
              mode_next = cee_pkg::MODE_NORMAL;
            end
          endcase
        end
        cee_pkg::MODE_HEX, cee_pkg::MODE_OCT: begin
          if (take_digit) begin
            number_accum_next = accum_shift;
            digit_count_next  = digit_count + 4'd1;
          end else begin
            mode_next = is_bslash ? cee_pkg::MODE_ESC : cee_pkg::MODE_NORMAL;
          end
        end
        cee_pkg::MODE_CTRL: begin
          mode_next = cee_pkg::MODE_NORMAL;
        end
        default: begin
          if (is_bslash) begin
            mode_next = cee_pkg::MODE_ESC;
          end
        end
      endcase
    end
  end

  // Emitted characters for this request.
  always_comb begin
    n_out = 2'd0;
    char0 = {11'b0, c};
    char1 = {11'b0, c};
    case (mode)
      cee_pkg::MODE_ESC: begin
        n_out = 2'd1;
        case (c) inside
          cee_pkg::CH_LC_A: char0 = cee_pkg::CTL_BEL;
          cee_pkg::CH_LC_B: char0 = cee_pkg::CTL_BS;
          cee_pkg::CH_LC_E, cee_pkg::CH_UC_E: char0 = cee_pkg::CTL_ESC;
          cee_pkg::CH_LC_F: char0 = cee_pkg::CTL_FF;
          cee_pkg::CH_LC_N: char0 = cee_pkg::CTL_LF;
          cee_pkg::CH_LC_R: char0 = cee_pkg::CTL_CR;
          cee_pkg::CH_LC_T: char0 = cee_pkg::CTL_HT;
          cee_pkg::CH_LC_V: char0 = cee_pkg::CTL_VT;
          cee_pkg::CH_LC_C: begin
            if (eot) begin
              n_out = 2'd2;
              char0 = {11'b0, cee_pkg::CH_BSLASH};
            end else begin
              n_out = 2'd0;
            end
          end
          cee_pkg::CH_LC_X, cee_pkg::CH_LC_U, cee_pkg::CH_UC_U: n_out = 2'd0;
          [cee_pkg::CH_DIG0:cee_pkg::CH_DIG7]: begin
            n_out = eot ? 2'd1 : 2'd0;
            char0 = {29'b0, c[2:0]};
          end
          cee_pkg::CH_BSLASH, cee_pkg::CH_QUEST, cee_pkg::CH_DQUOTE,
          cee_pkg::CH_SQUOTE: n_out = 2'd1;
          default: begin
            n_out = 2'd2;
            char0 = {11'b0, cee_pkg::CH_BSLASH};
          end
        endcase
      end
      cee_pkg::MODE_HEX, cee_pkg::MODE_OCT: begin
        if (take_digit) begin
          n_out = eot ? 2'd1 : 2'd0;
          char0 = accum_shift;
        end else if (digit_count != 4'd0) begin
          // The pending number goes first, then the terminating character.
          char0 = number_accum;
          n_out = (is_bslash && !eot) ? 2'd1 : 2'd2;
        end else begin
          n_out = (is_bslash && !eot) ? 2'd0 : 2'd1;
        end
      end
      cee_pkg::MODE_CTRL: begin
        n_out = 2'd1;
        char0 = {27'b0, c[4:0]};
      end
      default: begin
        n_out = (is_bslash && !eot) ? 2'd0 : 2'd1;
      end
    endcase
  end

  assign push           = accept && (n_out != 2'd0);
  assign push_req.two   = (n_out == 2'd2);
  assign push_req.char0 = char0;
  assign push_req.char1 = char1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= cee_pkg::MODE_NORMAL;
      digit_count  <= '0;
      digit_limit  <= '0;
      number_accum <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      digit_limit  <= digit_limit_next;
      number_accum <= number_accum_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/cee_queue.sv
`default_nettype none

module cee_queue #(
  parameter int DEPTH = cee_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  cee_pkg::req_t       push_req,
  output logic                full,
  input  wire logic           pop,
  output logic                nonempty,
  output cee_pkg::req_t       head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cee_pkg::req_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/cee_back.sv
`default_nettype none

module cee_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     nonempty,
  input  cee_pkg::req_t head,
  output logic          pop,
  cee_out_if.source     result
);

  logic        phase;
  logic        load;
  logic        last;
  logic        out_valid;
  logic [31:0] out_char;
  logic        out_last;

  // The output register refills whenever it is empty or being taken.
  assign load = !out_valid || result.ready;
  assign last = !head.two || phase;
  assign pop  = load && nonempty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= nonempty;
      if (nonempty) begin
        phase <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && nonempty) begin
      out_char <= phase ? head.char1 : head.char0;
      out_last <= last;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_char    = out_char;
  assign result.last_of_run = out_last;

endmodule

`default_nettype wire

FILE: src/c_escape_expander.sv
`default_nettype none

// Channel  Role    Payload                              Accepted when
// feed     sink    code_point[20:0], end_of_text        feed.valid && feed.ready
// result   source  out_char[31:0], last_of_run          result.valid && result.ready
//
// Each input character is scanned in the cycle it is accepted and leaves zero, one or
// two characters in a small request queue. The emitter drains that queue one character
// per cycle into an output register while the result channel is not stalled, so a
// request of two characters leaves as two results in turn; the single output port
// sets the pace, and the queue lets the scanner take new characters meanwhile.
// Reset (rst, synchronous) returns the scanner to plain text and empties the queue.
// A stalled output keeps accepting input until the queue is full.

module c_escape_expander #(
  parameter int QUEUE_DEPTH = cee_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  cee_in_if.sink    feed,
  cee_out_if.source result
);

  // Scanner to queue.
  cee_pkg::req_t push_req;
  logic          push;
  logic          queue_full;

  // Queue to emitter.
  cee_pkg::req_t head;
  logic          nonempty;
  logic          pop;

  // The scanner holds the escape state and turns each accepted character into a
  // request. It only stalls when the queue has no room.
  cee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .queue_full (queue_full),
    .push_req   (push_req),
    .push       (push)
  );

  // The queue decouples scanning from emission, so a stalled result channel
  // does not stop the scanner right away.
  cee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (queue_full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  // The emitter splits two-character requests and flags the last character of
  // each request with last_of_run.
  cee_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: src/cee_checker.sv
`default_nettype none

module cee_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        feed_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] res_char,
  input wire logic        res_last
);

  // A result waiting on the sink keeps its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_char) && $stable(res_last))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Reset leaves the input side open.
  a_reset_ready: assert property (@(posedge clk) rst |=> feed_ready)
    else $error("input not ready right after reset");

  // The second character of a pair follows the first without a gap.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_valid)
    else $error("second character of a pair missing");

endmodule

bind c_escape_expander cee_checker u_cee_checker (
  .clk        (clk),
  .rst        (rst),
  .feed_ready (feed.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_char   (result.out_char),
  .res_last   (result.last_of_run)
);

`default_nettype wire

FILE: dv/testbench.sv
module testbench;

  // One character waiting to be offered on the feed channel. A set hold_for_drain
  // keeps it back until every character already predicted has come out.
  typedef struct packed {
    logic [20:0] code_point;
    logic        end_of_text;
    logic        hold_for_drain;
  } feed_char_t;

  // One character the block is expected to emit.
  typedef struct packed {
    logic [31:0] out_char;
    logic        last_of_run;
  } emitted_char_t;

  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_TRIGGER = 400;
  localparam int TEXT_TARGET  = 2000;

  logic clk = 1'b0;
  logic rst;

  cee_in_if  feed();
  cee_out_if result();

  c_escape_expander u_top (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result)
  );

  always #2 clk = ~clk;

  feed_char_t    text_queue[$];
  emitted_char_t expected_chars[$];
  logic [31:0]   step_chars[$];

  // The scanner as the testbench sees it.
  cee_pkg::mode_t scan;
  logic [3:0]     digit_cnt;
  logic [3:0]     digit_max;
  logic [31:0]    number_val;

  logic          in_taken;
  int            errors = 0;
  int            results_seen = 0;
  int            cycle_cnt = 0;
  int            idle_cycles = 0;
  int            send_gap = 0;
  int            hold_left = 0;
  bit            long_hold_done = 1'b0;
  emitted_char_t want;

  // Named escapes and quoted punctuation; each of them yields exactly one character.
  logic [20:0] named_escapes[13] = '{cee_pkg::CH_LC_A, cee_pkg::CH_LC_B, cee_pkg::CH_LC_E,
                                     cee_pkg::CH_UC_E, cee_pkg::CH_LC_F, cee_pkg::CH_LC_N,
                                     cee_pkg::CH_LC_R, cee_pkg::CH_LC_T, cee_pkg::CH_LC_V,
                                     cee_pkg::CH_BSLASH, cee_pkg::CH_QUEST,
                                     cee_pkg::CH_DQUOTE, cee_pkg::CH_SQUOTE};

  // Most gaps are zero or short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One stretch in every four of the cycle count starts no random idling on either side.
  function automatic bit steady_phase();
    return (cycle_cnt % 2000) >= 1500;
  endfunction

  // Predict the characters that one accepted request emits and queue them up.
  task automatic expand_char(input logic [20:0] cp, input logic eot);
    int         d;
    logic       as_plain;
    logic [3:0] open_len;
    step_chars.delete();
    as_plain = 1'b0;
    open_len = 4'd0;
    case (scan)
      cee_pkg::MODE_ESC: begin
        scan = cee_pkg::MODE_NORMAL;
        case (cp)
          cee_pkg::CH_LC_A: step_chars.push_back(cee_pkg::CTL_BEL);
          cee_pkg::CH_LC_B: step_chars.push_back(cee_pkg::CTL_BS);
          cee_pkg::CH_LC_E, cee_pkg::CH_UC_E: step_chars.push_back(cee_pkg::CTL_ESC);
          cee_pkg::CH_LC_F: step_chars.push_back(cee_pkg::CTL_FF);
          cee_pkg::CH_LC_N: step_chars.push_back(cee_pkg::CTL_LF);
          cee_pkg::CH_LC_R: step_chars.push_back(cee_pkg::CTL_CR);
          cee_pkg::CH_LC_T: step_chars.push_back(cee_pkg::CTL_HT);
          cee_pkg::CH_LC_V: step_chars.push_back(cee_pkg::CTL_VT);
          cee_pkg::CH_LC_C: begin
            // A control escape cut off by the end of the text comes out literally.
            if (eot) begin
              step_chars.push_back({11'd0, cee_pkg::CH_BSLASH});
              step_chars.push_back({11'd0, cp});
            end else begin
              scan = cee_pkg::MODE_CTRL;
            end
          end
          cee_pkg::CH_LC_X: open_len = cee_pkg::LIM_X;
          cee_pkg::CH_LC_U: open_len = cee_pkg::LIM_U;
          cee_pkg::CH_UC_U: open_len = cee_pkg::LIM_UU;
          cee_pkg::CH_BSLASH, cee_pkg::CH_QUEST, cee_pkg::CH_DQUOTE,
          cee_pkg::CH_SQUOTE: step_chars.push_back({11'd0, cp});
          default: begin
            if (cp >= cee_pkg::CH_DIG0 && cp <= cee_pkg::CH_DIG7) begin
              digit_max  = cee_pkg::LIM_OCT;
              digit_cnt  = 4'd1;
              number_val = {29'd0, cp[2:0]};
              scan       = cee_pkg::MODE_OCT;
              if (eot) begin
                step_chars.push_back(number_val);
                scan = cee_pkg::MODE_NORMAL;
              end
            end else begin
              // Unknown escapes keep their backslash.
              step_chars.push_back({11'd0, cee_pkg::CH_BSLASH});
              step_chars.push_back({11'd0, cp});
            end
          end
        endcase
        if (open_len != 4'd0) begin
          digit_max  = open_len;
          digit_cnt  = 4'd0;
          number_val = 32'd0;
          scan       = cee_pkg::MODE_HEX;
        end
      end
      cee_pkg::MODE_HEX, cee_pkg::MODE_OCT: begin
        if (scan == cee_pkg::MODE_OCT) begin
          d = (cp >= cee_pkg::CH_DIG0 && cp <= cee_pkg::CH_DIG7) ?
              int'(cp - cee_pkg::CH_DIG0) : -1;
        end else if (cp >= cee_pkg::CH_DIG0 && cp <= cee_pkg::CH_DIG9) begin
          d = int'(cp - cee_pkg::CH_DIG0);
        end else if (cp >= cee_pkg::CH_LC_A && cp <= cee_pkg::CH_LC_F) begin
          d = int'(cp - cee_pkg::CH_LC_A) + 10;
        end else if (cp >= cee_pkg::CH_UC_A && cp <= cee_pkg::CH_UC_F) begin
          d = int'(cp - cee_pkg::CH_UC_A) + 10;
        end else begin
          d = -1;
        end
        if (d >= 0 && digit_cnt < digit_max) begin
          if (scan == cee_pkg::MODE_OCT) begin
            number_val = {number_val[28:0], d[2:0]};
          end else begin
            number_val = {number_val[27:0], d[3:0]};
          end
          digit_cnt = digit_cnt + 4'd1;
          if (eot) begin
            step_chars.push_back(number_val);
            scan = cee_pkg::MODE_NORMAL;
          end
        end else begin
          // The character that closes a number is scanned again as plain text.
          if (digit_cnt != 4'd0) step_chars.push_back(number_val);
          scan     = cee_pkg::MODE_NORMAL;
          as_plain = 1'b1;
        end
      end
      cee_pkg::MODE_CTRL: begin
        step_chars.push_back({27'd0, cp[4:0]});
        scan = cee_pkg::MODE_NORMAL;
      end
      default: as_plain = 1'b1;
    endcase
    if (as_plain) begin
      if (cp == cee_pkg::CH_BSLASH && !eot) scan = cee_pkg::MODE_ESC;
      else step_chars.push_back({11'd0, cp});
    end
    if (eot) begin
      scan       = cee_pkg::MODE_NORMAL;
      digit_cnt  = 4'd0;
      digit_max  = 4'd0;
      number_val = 32'd0;
    end
    for (int i = 0; i < step_chars.size(); i++) begin
      expected_chars.push_back('{step_chars[i], i == step_chars.size() - 1});
    end
  endtask

  task automatic add_char(input logic [20:0] cp, input logic eot);
    feed_char_t item;
    item.code_point     = cp;
    item.end_of_text    = eot;
    item.hold_for_drain = 1'b0;
    text_queue.push_back(item);
  endtask

  function automatic logic [20:0] random_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return cee_pkg::CH_DIG0 + 21'(r);
    if (r < 16) return cee_pkg::CH_LC_A + 21'(r - 10);
    return cee_pkg::CH_UC_A + 21'(r - 16);
  endfunction

  function automatic logic [20:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 21'($urandom_range(32'h20, 32'h7E));
    if (r < 85) return 21'($urandom_range(32'h80, 32'h10FFFF));
    return 21'($urandom_range(0, 32'h1FFFFF));
  endfunction

  // One text: a handful of pieces, mostly well-formed escapes with random content.
  task automatic add_random_text();
    int         kind;
    int         n;
    logic [3:0] lim;
    repeat ($urandom_range(1, 10)) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        add_char(random_char(), 1'b0);
      end else if (kind < 40) begin
        add_char(cee_pkg::CH_BSLASH, 1'b0);
        add_char(named_escapes[$urandom_range(0, 12)], 1'b0);
      end else if (kind < 50) begin
        add_char(cee_pkg::CH_BSLASH, 1'b0);
        add_char(random_char(), 1'b0);
      end else if (kind < 60) begin
        add_char(cee_pkg::CH_BSLASH, 1'b0);
        add_char(cee_pkg::CH_LC_C, 1'b0);
        add_char(random_char(), 1'b0);
      end else if (kind < 82) begin
        add_char(cee_pkg::CH_BSLASH, 1'b0);
        case ($urandom_range(0, 2))
          0: begin add_char(cee_pkg::CH_LC_X, 1'b0); lim = cee_pkg::LIM_X; end
          1: begin add_char(cee_pkg::CH_LC_U, 1'b0); lim = cee_pkg::LIM_U; end
          default: begin add_char(cee_pkg::CH_UC_U, 1'b0); lim = cee_pkg::LIM_UU; end
        endcase
        // Sometimes one digit more than the escape takes, so it spills into text.
        n = $urandom_range(0, lim + 1);
        repeat (n) add_char(random_hex_char(), 1'b0);
      end else if (kind < 95) begin
        add_char(cee_pkg::CH_BSLASH, 1'b0);
        repeat ($urandom_range(1, 4)) begin
          add_char(cee_pkg::CH_DIG0 + 21'($urandom_range(0, 7)), 1'b0);
        end
      end else begin
        add_char(21'($urandom_range(0, 32'h1FFFFF)), 1'($urandom_range(0, 1)));
      end
    end
    // Most texts are closed; the rest run straight into the next one.
    if ($urandom_range(0, 9) != 0) text_queue[text_queue.size() - 1].end_of_text = 1'b1;
  endtask

  // Directed texts: field extremes, code points past the Unicode range, a spread of
  // escape kinds, and several ways an escape can be cut short.
  task automatic add_directed_texts();
    add_char(21'h000000, 1'b0);
    add_char(21'h1FFFFF, 1'b0);
    add_char(21'h10FFFF, 1'b0);
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_LC_E, 1'b0);
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(21'h71, 1'b0);
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_DQUOTE, 1'b0);
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_LC_C, 1'b0);
    add_char(21'h5B, 1'b0);
    // Hex opener with no digits: only the following character comes out.
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_LC_X, 1'b0);
    add_char(21'h5A, 1'b0);
    // Full octal escape, then a digit that is not octal closes it.
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_DIG0 + 21'd1, 1'b0);
    add_char(cee_pkg::CH_DIG7, 1'b0); add_char(cee_pkg::CH_DIG7, 1'b0);
    add_char(cee_pkg::CH_DIG9, 1'b0);
    // Backslash as the last character of a text.
    add_char(cee_pkg::CH_BSLASH, 1'b1);
    // Control escape cut off by the end of the text.
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_LC_C, 1'b1);
    // Lone octal digit at the end of the text.
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_DIG0 + 21'd5, 1'b1);
    // Hex opener at the end of the text emits nothing.
    add_char(cee_pkg::CH_BSLASH, 1'b0); add_char(cee_pkg::CH_UC_U, 1'b1);
  endtask

  // Monitor: results are checked first, then an accepted request is predicted, so
  // both queues change in one process at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen = results_seen + 1;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result, out_char %h last_of_run %b", $time,
                   result.out_char, result.last_of_run);
          errors = errors + 1;
        end else begin
          want = expected_chars.pop_front();
          if (result.out_char !== want.out_char) begin
            $display("%0t: out_char expected %h, got %h", $time, want.out_char,
                     result.out_char);
            errors = errors + 1;
          end
          if (result.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run,
                     result.last_of_run);
            errors = errors + 1;
          end
        end
      end
      if (feed.valid && feed.ready) begin
        expand_char(feed.code_point, feed.end_of_text);
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
    end
  end

  // Driver: a request on offer stays until it is taken. After each one taken a gap
  // may follow. A request marked for a drain waits until nothing is outstanding.
  always @(negedge clk) begin
    if (rst) begin
      feed.valid <= 1'b0;
    end else if (!(feed.valid && !in_taken)) begin
      if (in_taken) begin
        void'(text_queue.pop_front());
        send_gap = steady_phase() ? 0 : pick_gap();
      end
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        feed.valid <= 1'b0;
      end else if (text_queue.size() != 0 &&
                   !(text_queue[0].hold_for_drain && expected_chars.size() != 0)) begin
        feed.valid       <= 1'b1;
        feed.code_point  <= text_queue[0].code_point;
        feed.end_of_text <= text_queue[0].end_of_text;
      end else begin
        feed.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering,
  // which fills the block's queue and must push back on the feed channel.
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_TRIGGER) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result.ready <= 1'b0;
    end else if (!steady_phase() && $urandom_range(0, 3) == 0) begin
      hold_left = pick_gap();
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst || (feed.valid && feed.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    feed.valid       = 1'b0;
    feed.code_point  = '0;
    feed.end_of_text = 1'b0;
    result.ready     = 1'b0;
    scan             = cee_pkg::MODE_NORMAL;
    digit_cnt        = 4'd0;
    digit_max        = 4'd0;
    number_val       = 32'd0;

    add_directed_texts();
    while (text_queue.size() < TEXT_TARGET) add_random_text();
    // Midway the sender pauses until every outstanding character has come out.
    text_queue[text_queue.size() / 2].hold_for_drain = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cee_pkg.sv
src/cee_in_if.sv
src/cee_out_if.sv
src/cee_front.sv
src/cee_queue.sv
src/cee_back.sv
src/c_escape_expander.sv
src/cee_checker.sv
dv/testbench.sv
